// ===== hw/rtl/tgp_pkg.sv =====
package tgp_pkg;

	localparam int TGP_MAX_TILES      = 1024;
	localparam int TGP_WORDS_PER_TILE = 16;
	localparam int TGP_WORD_W         = 4;
	localparam int TGP_ADDR_MAX_W     = 16;
	localparam int TGP_TN_W           = 13;
	localparam int TGP_QDEPTH         = 2;

	typedef enum logic [1:0] {
		CMD_PLOT  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	localparam logic [2:0] REG_WIN_W    = 3'd0;
	localparam logic [2:0] REG_WIN_H    = 3'd1;
	localparam logic [2:0] REG_WRAP     = 3'd2;
	localparam logic [2:0] REG_LIGHT    = 3'd3;
	localparam logic [2:0] REG_SHADOW   = 3'd4;
	localparam logic [2:0] REG_DARK     = 3'd5;
	localparam logic [2:0] REG_BG       = 3'd6;
	localparam logic [2:0] REG_WRITE_BG = 3'd7;

	typedef struct packed {
		logic [5:0] win_w;
		logic [5:0] win_h;
		logic [1:0] wrap;
		logic [3:0] c_light;
		logic [3:0] c_shadow;
		logic [3:0] c_dark;
		logic [3:0] c_bg;
		logic       write_bg;
	} cfg_t;

	typedef struct packed {
		logic                      is_read;
		logic                      rd_ok;
		logic                      wr0;
		logic                      wr1;
		logic [TGP_ADDR_MAX_W-1:0] addr0;
		logic [TGP_ADDR_MAX_W-1:0] addr1;
		logic [15:0]               mask0;
		logic [15:0]               paint0;
		logic [15:0]               mask1;
		logic [15:0]               paint1;
	} job_t;

endpackage

// ===== hw/rtl/tgp_wrap_unit.sv =====
module tgp_wrap_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic signed [6:0] value,
	input  logic [5:0]        modulus,
	output logic              done,
	output logic [5:0]        result
);
	localparam int STEPS = 7;
	localparam logic [2:0] LAST_STEP = 3'(STEPS - 1);

	logic       run_q;
	logic       done_q;
	logic [2:0] cnt_q;
	logic [6:0] mag_q;
	logic [5:0] rem_q;
	logic       neg_q;
	logic [6:0] trial;
	logic       ge;
	logic [5:0] rem_next;

	always_comb begin
		trial    = {rem_q, mag_q[6]};
		ge       = trial >= {1'b0, modulus};
		rem_next = ge ? 6'(trial - {1'b0, modulus}) : trial[5:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == LAST_STEP) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one remainder bit per cycle on the magnitude
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= value[6];
			mag_q <= value[6] ? (~value + 7'd1) : value;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= rem_next;
			mag_q <= {mag_q[5:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = (neg_q && rem_q != 6'd0) ? (modulus - rem_q) : rem_q;

endmodule

// ===== hw/rtl/tgp_front.sv =====
module tgp_front #(
	parameter int MAX_TILES = tgp_pkg::TGP_MAX_TILES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         cmd,
	input  logic signed [9:0]  pixel_x,
	input  logic signed [9:0]  pixel_y,
	input  logic [15:0]        glyph_word,
	input  logic [3:0]         clear_color,
	input  logic [9:0]         tile_index,
	input  logic [3:0]         word_index,
	input  tgp_pkg::cfg_t      cfg,
	input  logic               space,
	output logic               busy,
	output logic               push,
	output tgp_pkg::job_t      job
);
	import tgp_pkg::*;

	localparam int TILE_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int ADDR_W = TILE_W + TGP_WORD_W;
	localparam logic [TGP_TN_W-1:0] MAX_TN = TGP_TN_W'(MAX_TILES);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_EVAL = 4'b0010,
		F_MOD  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t state_q;

	logic [1:0]        cmd_q;
	logic signed [9:0] px_q;
	logic signed [9:0] py_q;
	logic [15:0]       glyph_q;
	logic [3:0]        ccol_q;
	logic [9:0]        tidx_q;
	logic [3:0]        widx_q;
	logic              need_x_q;
	logic              need_y_q;

	logic signed [6:0] tile_y;
	logic signed [6:0] tile_x;
	logic [2:0]        sub_y;
	logic [2:0]        sub_x;
	logic              is_plot;
	logic              is_clear;
	logic              is_read;
	logic              wx;
	logic              wy;
	logic              zero_win;
	logic              y_out;
	logic              x_out;
	logic              need_x;
	logic              need_y;
	logic              mod_start;
	logic              y_done;
	logic              x_done;
	logic [5:0]        y_res;
	logic [5:0]        x_res;
	logic [5:0]        ty;
	logic              row_ok;
	logic signed [7:0] w8;
	logic signed [7:0] tx0;
	logic signed [7:0] tx1_inc;
	logic signed [7:0] tx1;
	logic              x0_in;
	logic              x1_in;
	logic [11:0]       row_base;
	logic [TGP_TN_W-1:0] tn0;
	logic [TGP_TN_W-1:0] tn1;
	logic [TGP_TN_W-1:0] rd_tn;
	logic [15:0]       mask;
	logic [15:0]       paint;
	logic [31:0]       mask_ext;
	logic [31:0]       paint_ext;
	logic [3:0]        word0;
	logic [3:0]        word1;
	logic [ADDR_W-1:0] wa0;
	logic [ADDR_W-1:0] wa1;
	logic [ADDR_W-1:0] ra;

	always_comb begin
		tile_y   = py_q[9:3];
		sub_y    = py_q[2:0];
		tile_x   = px_q[9:3];
		sub_x    = px_q[2:0];
		is_plot  = cmd_q == CMD_PLOT;
		is_clear = cmd_q == CMD_CLEAR;
		is_read  = cmd_q == CMD_READ;
		wx       = is_plot && cfg.wrap[0];
		wy       = is_plot && cfg.wrap[1];
		zero_win = (cfg.win_w == 6'd0) || (cfg.win_h == 6'd0);
		y_out    = tile_y[6] || (tile_y[5:0] >= cfg.win_h);
		x_out    = tile_x[6] || (tile_x[5:0] >= cfg.win_w);
		need_y   = !zero_win && y_out && wy;
		need_x   = !zero_win && x_out && wx;
	end

	assign mod_start = (state_q == F_EVAL) && (need_x || need_y);

	tgp_wrap_unit u_wrap_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.value   (tile_y),
		.modulus (cfg.win_h),
		.done    (y_done),
		.result  (y_res)
	);

	tgp_wrap_unit u_wrap_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.value   (tile_x),
		.modulus (cfg.win_w),
		.done    (x_done),
		.result  (x_res)
	);

	always_comb begin
		ty       = need_y_q ? y_res : tile_y[5:0];
		row_ok   = !zero_win && (!y_out || wy) && (is_plot || is_clear);
		w8       = $signed({2'b00, cfg.win_w});
		tx0      = need_x_q ? $signed({2'b00, x_res}) : {tile_x[6], tile_x};
		tx1_inc  = tx0 + 8'sd1;
		if (!sub_x[2]) begin
			tx1 = tx0;
		end else if (wx && tx1_inc == w8) begin
			tx1 = 8'sd0;
		end else begin
			tx1 = tx1_inc;
		end
		x0_in    = !tx0[7] && (tx0 < w8);
		x1_in    = !tx1[7] && (tx1 < w8);
		row_base = ty * cfg.win_w;
		tn0      = {1'b0, row_base} + {7'b0, tx0[5:0]};
		tn1      = {1'b0, row_base} + {7'b0, tx1[5:0]};
		rd_tn    = TGP_TN_W'(tidx_q);
		word0    = {sub_y, sub_x[2]};
		word1    = {sub_y, ~sub_x[2]};
		wa0      = {tn0[TILE_W-1:0], word0};
		wa1      = {tn1[TILE_W-1:0], word1};
		ra       = {rd_tn[TILE_W-1:0], widx_q};
	end

	// per-pixel mask and colour
	always_comb begin
		logic [3:0] nib;
		logic       bg;
		mask  = '0;
		paint = '0;
		for (int i = 0; i < 4; i++) begin
			nib = glyph_q[4*i +: 4];
			bg  = cfg.write_bg && nib[3];
			mask[4*i +: 4]  = (nib[0] || nib[1] || nib[2] || bg) ? 4'hF : 4'h0;
			paint[4*i +: 4] = ({4{nib[0]}} & cfg.c_light) | ({4{nib[1]}} & cfg.c_shadow) |
				({4{nib[2]}} & cfg.c_dark) | ({4{bg}} & cfg.c_bg);
		end
		if (is_clear) begin
			mask  = 16'hFFFF;
			paint = {4{ccol_q}};
		end
		mask_ext  = {16'h0000, mask} << {sub_x[1:0], 2'b00};
		paint_ext = {16'h0000, paint} << {sub_x[1:0], 2'b00};
	end

	always_comb begin
		job.is_read = is_read;
		job.rd_ok   = is_read && (rd_tn < MAX_TN);
		job.wr0     = row_ok && x0_in && (tn0 < MAX_TN);
		job.wr1     = row_ok && (sub_x[1:0] != 2'd0) && x1_in && (tn1 < MAX_TN);
		job.addr0   = is_read ? TGP_ADDR_MAX_W'(ra) : TGP_ADDR_MAX_W'(wa0);
		job.addr1   = TGP_ADDR_MAX_W'(wa1);
		job.mask0   = mask_ext[15:0];
		job.paint0  = paint_ext[15:0];
		job.mask1   = mask_ext[31:16];
		job.paint1  = paint_ext[31:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) state_q <= F_EVAL;
				end
				F_EVAL: begin
					state_q <= (need_x || need_y) ? F_MOD : F_PUSH;
				end
				F_MOD: begin
					if (y_done && x_done) state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (space) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			px_q    <= pixel_x;
			py_q    <= pixel_y;
			glyph_q <= glyph_word;
			ccol_q  <= clear_color;
			tidx_q  <= tile_index;
			widx_q  <= word_index;
		end
		if (state_q == F_EVAL) begin
			need_x_q <= need_x;
			need_y_q <= need_y;
		end
	end

	assign busy = state_q != F_IDLE;
	assign push = (state_q == F_PUSH) && space;

endmodule

// ===== hw/rtl/tgp_back.sv =====
module tgp_back #(
	parameter int MAX_TILES = tgp_pkg::TGP_MAX_TILES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tgp_pkg::job_t job_in,
	output logic          space,
	output logic          clearing,
	output logic          done,
	output logic [15:0]   read_data,
	output logic [1:0]    words_written
);
	import tgp_pkg::*;

	localparam int TILE_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int ADDR_W = TILE_W + TGP_WORD_W;
	localparam int DEPTH  = MAX_TILES * TGP_WORDS_PER_TILE;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam int PTR_W  = (TGP_QDEPTH > 1) ? $clog2(TGP_QDEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(TGP_QDEPTH - 1);
	localparam logic [PTR_W:0]   FULL_CNT = (PTR_W + 1)'(TGP_QDEPTH);

	typedef enum logic [3:0] {
		B_CLEAR  = 4'b0001,
		B_IDLE   = 4'b0010,
		B_FIRST  = 4'b0100,
		B_SECOND = 4'b1000
	} bstate_t;

	bstate_t state_q;

	job_t              q_mem_q [TGP_QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    cnt_q;
	job_t              head;
	job_t              cur_q;
	logic              pop;
	logic              fin;

	logic [15:0]       mem [DEPTH];
	logic [15:0]       mem_rdata_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [15:0]       mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [ADDR_W-1:0] clr_cnt_q;

	logic              done_q;
	logic [15:0]       read_data_q;
	logic [1:0]        words_q;

	assign head  = q_mem_q[rd_ptr_q];
	assign pop   = (state_q == B_IDLE) && (cnt_q != '0);
	assign fin   = ((state_q == B_FIRST) && !cur_q.wr1) || (state_q == B_SECOND);
	assign space = cnt_q != FULL_CNT;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q.addr0[ADDR_W-1:0];
		mem_wdata = (mem_rdata_q & ~cur_q.mask0) | (cur_q.paint0 & cur_q.mask0);
		mem_raddr = cur_q.addr0[ADDR_W-1:0];
		case (state_q)
			B_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
			end
			B_IDLE: begin
				mem_raddr = head.addr0[ADDR_W-1:0];
			end
			B_FIRST: begin
				mem_we    = cur_q.wr0;
				mem_raddr = cur_q.addr1[ADDR_W-1:0];
			end
			B_SECOND: begin
				mem_we    = 1'b1;
				mem_waddr = cur_q.addr1[ADDR_W-1:0];
				mem_wdata = (mem_rdata_q & ~cur_q.mask1) | (cur_q.paint1 & cur_q.mask1);
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_cnt_q <= '0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= fin;
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
			case (state_q)
				B_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == LAST_ADDR) state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (pop) state_q <= B_FIRST;
				end
				B_FIRST: begin
					state_q <= cur_q.wr1 ? B_SECOND : B_IDLE;
				end
				B_SECOND: begin
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= job_in;
		if (pop) cur_q <= head;
		if (fin) begin
			read_data_q <= (cur_q.is_read && cur_q.rd_ok) ? mem_rdata_q : 16'h0000;
			words_q     <= {1'b0, cur_q.wr0} + {1'b0, cur_q.wr1};
		end
	end

	assign clearing      = state_q == B_CLEAR;
	assign done          = done_q;
	assign read_data     = read_data_q;
	assign words_written = words_q;

endmodule

// ===== hw/rtl/tile_glyph_plotter.sv =====
// flow: the front classifies a request and pushes a job; the back pops it, reads and merges the
// first halfword and, when a second halfword is modified, that one too, then strobes done;
// a plot that wraps an out-of-window row or column first passes through the 7-step wrap units
// the front takes a new request only when idle; the back handles one job at a time from its queue
// reset: after arst_n releases, busy stays high while the store is zeroed
// results go out on a one-cycle done strobe; the receiver cannot stall
module tile_glyph_plotter #(
	parameter int MAX_TILES = tgp_pkg::TGP_MAX_TILES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        cmd,
	input  logic signed [9:0] pixel_x,
	input  logic signed [9:0] pixel_y,
	input  logic [15:0]       glyph_word,
	input  logic [3:0]        clear_color,
	input  logic [9:0]        tile_index,
	input  logic [3:0]        word_index,
	output logic              done,
	output logic [15:0]       read_data,
	output logic [1:0]        words_written,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [5:0]        cfg_data
);
	import tgp_pkg::*;

	cfg_t cfg_q;
	job_t job;
	logic front_busy;
	logic clearing;
	logic accept;
	logic push;
	logic space;

	assign cfg_ready = 1'b1;
	assign busy      = front_busy || clearing;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_w    <= 6'd30;
			cfg_q.win_h    <= 6'd20;
			cfg_q.wrap     <= 2'd0;
			cfg_q.c_light  <= 4'd0;
			cfg_q.c_shadow <= 4'd0;
			cfg_q.c_dark   <= 4'd0;
			cfg_q.c_bg     <= 4'd0;
			cfg_q.write_bg <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIN_W:    cfg_q.win_w    <= cfg_data;
				REG_WIN_H:    cfg_q.win_h    <= cfg_data;
				REG_WRAP:     cfg_q.wrap     <= cfg_data[1:0];
				REG_LIGHT:    cfg_q.c_light  <= cfg_data[3:0];
				REG_SHADOW:   cfg_q.c_shadow <= cfg_data[3:0];
				REG_DARK:     cfg_q.c_dark   <= cfg_data[3:0];
				REG_BG:       cfg_q.c_bg     <= cfg_data[3:0];
				REG_WRITE_BG: cfg_q.write_bg <= cfg_data[0];
				default:      cfg_q.write_bg <= cfg_q.write_bg;
			endcase
		end
	end

	tgp_front #(
		.MAX_TILES (MAX_TILES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cmd         (cmd),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.glyph_word  (glyph_word),
		.clear_color (clear_color),
		.tile_index  (tile_index),
		.word_index  (word_index),
		.cfg         (cfg_q),
		.space       (space),
		.busy        (front_busy),
		.push        (push),
		.job         (job)
	);

	tgp_back #(
		.MAX_TILES (MAX_TILES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.job_in        (job),
		.space         (space),
		.clearing      (clearing),
		.done          (done),
		.read_data     (read_data),
		.words_written (words_written)
	);

	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobes on two cycles in a row");

	a_write_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && words_written != 2'd0) |-> (read_data == 16'h0000))
		else $error("writing request returned read data");

	a_words_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (words_written != 2'd3))
		else $error("more than two halfwords written");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy did not rise after a request");

endmodule

// ===== dv/tile_glyph_plotter_tb.sv =====
`timescale 1ns / 100ps

module tile_glyph_plotter_tb;
	import tgp_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int STORE_WORDS = TGP_MAX_TILES * TGP_WORDS_PER_TILE;

	typedef struct {
		logic [15:0] data;
		logic [1:0]  count;
	} outcome_t;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              start       = 1'b0;
	logic              busy;
	logic [1:0]        cmd         = '0;
	logic signed [9:0] pixel_x     = '0;
	logic signed [9:0] pixel_y     = '0;
	logic [15:0]       glyph_word  = '0;
	logic [3:0]        clear_color = '0;
	logic [9:0]        tile_index  = '0;
	logic [3:0]        word_index  = '0;
	logic              done;
	logic [15:0]       read_data;
	logic [1:0]        words_written;
	logic              cfg_valid   = 1'b0;
	logic              cfg_ready;
	logic [2:0]        cfg_index   = '0;
	logic [5:0]        cfg_data    = '0;

	cfg_t        model_cfg;
	logic [15:0] frame_image [STORE_WORDS];
	outcome_t    pending_outcomes [$];
	int          mismatches = 0;

	tile_glyph_plotter dut (
		.clk, .arst_n, .start, .busy, .cmd, .pixel_x, .pixel_y, .glyph_word,
		.clear_color, .tile_index, .word_index, .done, .read_data, .words_written,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#500000;
		$display("status: fail");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [15:0] got, want);
		if (mismatches < 40)
			$display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic int wrap_index(input int v, input int n);
		int m;
		m = v % n;
		if (m < 0)
			m += n;
		return m;
	endfunction

	function automatic int merge_halfword(input int tile, input int word,
			input logic [15:0] mask, input logic [15:0] paint);
		int addr;
		if (tile < 0 || tile >= TGP_MAX_TILES)
			return 0;
		addr = tile * TGP_WORDS_PER_TILE + (word & 15);
		frame_image[addr] = (frame_image[addr] & ~mask) | (paint & mask);
		return 1;
	endfunction

	function automatic int place_four(input int px, input int py, input logic [15:0] mask,
			input logic [15:0] paint, input bit wx, input bit wy);
		int w, h, tile_y, sub_y, tile_x, sub_x, shift, word, count;
		w = model_cfg.win_w;
		h = model_cfg.win_h;
		tile_y = ((py + 512) >> 3) - 64;
		sub_y = (py + 512) & 7;
		tile_x = ((px + 512) >> 3) - 64;
		sub_x = (px + 512) & 7;
		shift = (sub_x & 3) * 4;
		word = sub_y * 2 + (sub_x >> 2);
		count = 0;
		if (w == 0 || h == 0)
			return 0;
		if (tile_y < 0 || tile_y >= h) begin
			if (!wy)
				return 0;
			tile_y = wrap_index(tile_y, h);
		end
		if ((tile_x < 0 || tile_x >= w) && wx)
			tile_x = wrap_index(tile_x, w);
		if (tile_x >= 0 && tile_x < w)
			count += merge_halfword(tile_y * w + tile_x, word, mask << shift, paint << shift);
		if (shift == 0)
			return count;
		if (sub_x < 4) begin
			word += 1;
		end else begin
			tile_x += 1;
			word -= 1;
			if ((tile_x < 0 || tile_x >= w) && wx)
				tile_x = wrap_index(tile_x, w);
		end
		if (tile_x >= 0 && tile_x < w)
			count += merge_halfword(tile_y * w + tile_x, word, mask >> (16 - shift),
				paint >> (16 - shift));
		return count;
	endfunction

	function automatic outcome_t model_request(input logic [1:0] op, input int px, input int py,
			input logic [15:0] glyph, input logic [3:0] colour, input logic [9:0] tile,
			input logic [3:0] word);
		outcome_t    res;
		logic [15:0] b0, b1, b2, b3, mask, paint;
		res.data = '0;
		res.count = '0;
		case (op)
			CMD_PLOT: begin
				b0 = glyph & 16'h1111;
				b1 = (glyph >> 1) & 16'h1111;
				b2 = (glyph >> 2) & 16'h1111;
				b3 = (glyph >> 3) & 16'h1111;
				mask = (b0 | b1 | b2) * 16'hF;
				paint = (b0 * model_cfg.c_light) | (b1 * model_cfg.c_shadow)
					| (b2 * model_cfg.c_dark);
				if (model_cfg.write_bg) begin
					mask |= b3 * 16'hF;
					paint |= b3 * model_cfg.c_bg;
				end
				res.count = 2'(place_four(px, py, mask, paint, model_cfg.wrap[0],
					model_cfg.wrap[1]));
			end
			CMD_CLEAR: begin
				res.count = 2'(place_four(px, py, 16'hFFFF, 16'h1111 * colour, 1'b0, 1'b0));
			end
			CMD_READ: begin
				res.data = frame_image[{tile, word}];
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("result with no request outstanding", read_data, '0);
			end else begin
				want = pending_outcomes.pop_front();
				if (read_data !== want.data)
					report_mismatch("read_data", read_data, want.data);
				if (words_written !== want.count)
					report_mismatch("words_written", 16'(words_written), 16'(want.count));
			end
		end
	end

	task automatic send_request(input logic [1:0] op, input logic signed [9:0] x, y,
			input logic [15:0] glyph, input logic [3:0] colour, input logic [9:0] tile,
			input logic [3:0] word);
		start <= 1'b1;
		cmd <= op;
		pixel_x <= x;
		pixel_y <= y;
		glyph_word <= glyph;
		clear_color <= colour;
		tile_index <= tile;
		word_index <= word;
		do @(posedge clk); while (busy);
		pending_outcomes.push_back(model_request(op, x, y, glyph, colour, tile, word));
	endtask

	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_config(input logic [5:0] w, h, wrap, light, shadow, dark, bg, wbg);
		logic [5:0] values [8];
		values = '{w, h, wrap, light, shadow, dark, bg, wbg};
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= values[i];
			do @(posedge clk); while (!cfg_ready);
			case (3'(i))
				REG_WIN_W:    model_cfg.win_w = values[i];
				REG_WIN_H:    model_cfg.win_h = values[i];
				REG_WRAP:     model_cfg.wrap = values[i][1:0];
				REG_LIGHT:    model_cfg.c_light = values[i][3:0];
				REG_SHADOW:   model_cfg.c_shadow = values[i][3:0];
				REG_DARK:     model_cfg.c_dark = values[i][3:0];
				REG_BG:       model_cfg.c_bg = values[i][3:0];
				REG_WRITE_BG: model_cfg.write_bg = values[i][0];
				default: begin
				end
			endcase
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [9:0] pick_coord(input int span);
		int hi;
		if ($urandom_range(4, 0) == 0)
			return 10'($urandom);
		hi = (span + 8 > 511) ? 511 : span + 8;
		return 10'(int'($urandom_range(hi + 16, 0)) - 16);
	endfunction

	task automatic send_random_request();
		logic [1:0]        op;
		logic signed [9:0] x, y;
		logic [15:0]       glyph;
		logic [9:0]        tile;
		logic [3:0]        word;
		int                pick, w, h;
		pick = $urandom_range(99, 0);
		op = (pick < 45) ? CMD_PLOT : (pick < 65) ? CMD_CLEAR : (pick < 95) ? CMD_READ
			: CMD_UNUSED;
		w = model_cfg.win_w;
		h = model_cfg.win_h;
		x = pick_coord(w * 8);
		y = pick_coord(h * 8);
		glyph = 16'($urandom);
		if (pick % 10 == 3)
			glyph = '0;
		else if (pick % 10 == 7)
			glyph = 16'hFFFF;
		tile = 10'($urandom);
		word = 4'($urandom);
		if (op == CMD_READ && w > 0 && h > 0 && $urandom_range(9, 0) < 7)
			tile = 10'(int'($urandom_range(h - 1, 0)) * w + int'($urandom_range(w - 1, 0)));
		send_request(op, x, y, glyph, 4'($urandom), tile, word);
	endtask

	task automatic test_plot_and_clear_edges();
		load_config(6'd30, 6'd20, 6'd0, 6'd1, 6'd2, 6'd4, 6'd8, 6'd0);
		send_request(CMD_PLOT, 10'sd0, 10'sd0, 16'hFFFF, 4'h0, '0, '0);
		send_request(CMD_PLOT, 10'sd2, 10'sd0, 16'h8421, 4'h0, '0, '0);
		send_request(CMD_PLOT, 10'sd6, 10'sd1, 16'h1234, 4'h0, '0, '0);
		send_request(CMD_PLOT, -10'sd2, 10'sd0, 16'h7777, 4'h0, '0, '0);
		send_request(CMD_PLOT, 10'sd238, 10'sd5, 16'h5555, 4'h0, '0, '0);
		send_request(CMD_PLOT, -10'sd512, -10'sd512, 16'hFFFF, 4'h0, '0, '0);
		send_request(CMD_PLOT, 10'sd511, 10'sd511, 16'hFFFF, 4'h0, '0, '0);
		send_request(CMD_PLOT, 10'sd16, 10'sd159, 16'h0000, 4'h0, '0, '0);
		send_request(CMD_CLEAR, 10'sd9, 10'sd8, 16'h0000, 4'hF, '0, '0);
		send_request(CMD_CLEAR, -10'sd3, 10'sd3, 16'h0000, 4'hA, '0, '0);
		send_request(CMD_READ, '0, '0, '0, '0, 10'd0, 4'd1);
		send_request(CMD_READ, '0, '0, '0, '0, 10'd0, 4'd6);
		send_request(CMD_READ, '0, '0, '0, '0, 10'd1, 4'd2);
		send_request(CMD_UNUSED, -10'sd1, -10'sd1, 16'hFFFF, 4'hF, 10'h3FF, 4'hF);
		send_request(CMD_READ, '0, '0, '0, '0, 10'd1023, 4'd15);
		wait_idle();
	endtask

	task automatic test_wrap_and_background();
		load_config(6'd30, 6'd20, 6'd3, 6'd3, 6'd5, 6'd9, 6'd12, 6'd1);
		send_request(CMD_PLOT, -10'sd1, -10'sd1, 16'hFFFF, 4'h0, '0, '0);
		send_request(CMD_PLOT, -10'sd512, 10'sd511, 16'h8888, 4'h0, '0, '0);
		send_request(CMD_PLOT, 10'sd239, 10'sd0, 16'h1248, 4'h0, '0, '0);
		send_request(CMD_CLEAR, -10'sd1, -10'sd1, 16'h0000, 4'h5, '0, '0);
		send_request(CMD_READ, '0, '0, '0, '0, 10'd599, 4'd15);
		send_request(CMD_READ, '0, '0, '0, '0, 10'd0, 4'd0);
		wait_idle();
		load_config(6'd30, 6'd20, 6'd1, 6'd7, 6'd0, 6'd0, 6'd15, 6'd1);
		send_request(CMD_PLOT, 10'sd5, -10'sd3, 16'hFFFF, 4'h0, '0, '0);
		wait_idle();
		load_config(6'd30, 6'd20, 6'd2, 6'd7, 6'd0, 6'd0, 6'd15, 6'd0);
		send_request(CMD_PLOT, -10'sd4, 10'sd165, 16'hFFFF, 4'h0, '0, '0);
		wait_idle();
	endtask

	task automatic test_window_extremes();
		load_config(6'd0, 6'd20, 6'd3, 6'd15, 6'd15, 6'd15, 6'd15, 6'd1);
		send_request(CMD_PLOT, 10'sd0, 10'sd0, 16'hFFFF, 4'h0, '0, '0);
		send_request(CMD_CLEAR, 10'sd0, 10'sd0, 16'h0000, 4'h3, '0, '0);
		wait_idle();
		load_config(6'd63, 6'd63, 6'd3, 6'd6, 6'd9, 6'd2, 6'd11, 6'd1);
		send_request(CMD_PLOT, 10'sd500, 10'sd500, 16'hFFFF, 4'h0, '0, '0);
		send_request(CMD_PLOT, 10'sd120, 10'sd120, 16'h9AF3, 4'h0, '0, '0);
		send_request(CMD_PLOT, 10'sd504, 10'sd0, 16'hFFFF, 4'h0, '0, '0);
		send_request(CMD_READ, '0, '0, '0, '0, 10'd960, 4'd0);
		wait_idle();
		load_config(6'd32, 6'd32, 6'd0, 6'd13, 6'd0, 6'd0, 6'd0, 6'd0);
		send_request(CMD_PLOT, 10'sd255, 10'sd255, 16'hFFFF, 4'h0, '0, '0);
		send_request(CMD_READ, '0, '0, '0, '0, 10'd1023, 4'd15);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int         phase, n;
		logic [5:0] w, h;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin w = 6'd30; h = 6'd20; end
				1: begin w = 6'd1;  h = 6'd1;  end
				2: begin w = 6'd32; h = 6'd32; end
				3: begin w = 6'd63; h = 6'd40; end
				default: begin
					w = 6'($urandom_range(32, 1));
					h = 6'($urandom_range(32, 1));
				end
			endcase
			load_config(w, h, 6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom),
				6'($urandom), 6'($urandom));
			for (n = 0; n < 85; n++) begin
				send_random_request();
				if (phase < 5 && $urandom_range(3, 0) == 0)
					pause_sender($urandom_range(6, 1));
			end
			wait_idle();
		end
	endtask

	initial begin
		model_cfg = '{win_w: 6'd30, win_h: 6'd20, default: '0};
		foreach (frame_image[i])
			frame_image[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (busy);
		test_plot_and_clear_edges();
		test_wrap_and_background();
		test_window_extremes();
		test_random_traffic();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
